### design/chip8_instruction_core_top_assert.svh
// Assertion macros for the CHIP-8 instruction core.
// Used by the controller and the top level; depends on nothing.
`ifndef CHIP8_INSTRUCTION_CORE_TOP_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_TOP_ASSERT_SVH
// Checks that an implication holds at every clock edge out of reset.
`define C8_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define C8_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/c8core_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the font table of the CHIP-8 instruction core.
// Depends on nothing.
package c8core_pkg;

  localparam int unsigned MemSize    = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned FontBase   = 80;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam logic [11:0] PcReset    = 12'h200;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_EXEC  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_ROW   = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] mem_addr;
    logic [7:0]  mem_byte;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } in_item_t;

  typedef struct packed {
    logic [11:0] cur_pc;
    logic [15:0] fetched_opcode;
    logic        drew;
    logic        sound_on;
    logic [63:0] row_bits;
    logic        waiting_for_key;
    logic        stack_fault;
  } out_item_t;

  // Datapath operation selected by the controller for one cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK,
    OP_ROW_RD,
    OP_ROW_OUT,
    OP_FETCH_HI,
    OP_FETCH_LO,
    OP_EXEC,
    OP_CLS,
    OP_DRAW_RD,
    OP_DRAW_ROW,
    OP_DRAW_WR,
    OP_DRAW_END,
    OP_BCD,
    OP_STORE,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic [7:0]  rd;
    logic        init_done;
  } dp_status_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] r;
    case (idx)
      7'd0: r = 8'hF0; 7'd1: r = 8'h90; 7'd2: r = 8'h90; 7'd3: r = 8'h90; 7'd4: r = 8'hF0;
      7'd5: r = 8'h20; 7'd6: r = 8'h60; 7'd7: r = 8'h20; 7'd8: r = 8'h20; 7'd9: r = 8'h70;
      7'd10: r = 8'hF0; 7'd11: r = 8'h10; 7'd12: r = 8'hF0; 7'd13: r = 8'h80; 7'd14: r = 8'hF0;
      7'd15: r = 8'hF0; 7'd16: r = 8'h10; 7'd17: r = 8'hF0; 7'd18: r = 8'h10; 7'd19: r = 8'hF0;
      7'd20: r = 8'h90; 7'd21: r = 8'h90; 7'd22: r = 8'hF0; 7'd23: r = 8'h10; 7'd24: r = 8'h10;
      7'd25: r = 8'hF0; 7'd26: r = 8'h80; 7'd27: r = 8'hF0; 7'd28: r = 8'h10; 7'd29: r = 8'hF0;
      7'd30: r = 8'hF0; 7'd31: r = 8'h80; 7'd32: r = 8'hF0; 7'd33: r = 8'h90; 7'd34: r = 8'hF0;
      7'd35: r = 8'hF0; 7'd36: r = 8'h10; 7'd37: r = 8'h20; 7'd38: r = 8'h40; 7'd39: r = 8'h40;
      7'd40: r = 8'hF0; 7'd41: r = 8'h90; 7'd42: r = 8'hF0; 7'd43: r = 8'h90; 7'd44: r = 8'hF0;
      7'd45: r = 8'hF0; 7'd46: r = 8'h90; 7'd47: r = 8'hF0; 7'd48: r = 8'h10; 7'd49: r = 8'hF0;
      7'd50: r = 8'hF0; 7'd51: r = 8'h90; 7'd52: r = 8'hF0; 7'd53: r = 8'h90; 7'd54: r = 8'h90;
      7'd55: r = 8'hE0; 7'd56: r = 8'h90; 7'd57: r = 8'hE0; 7'd58: r = 8'h90; 7'd59: r = 8'hE0;
      7'd60: r = 8'hF0; 7'd61: r = 8'h80; 7'd62: r = 8'h80; 7'd63: r = 8'h80; 7'd64: r = 8'hF0;
      7'd65: r = 8'hE0; 7'd66: r = 8'h90; 7'd67: r = 8'h90; 7'd68: r = 8'h90; 7'd69: r = 8'hE0;
      7'd70: r = 8'hF0; 7'd71: r = 8'h80; 7'd72: r = 8'hF0; 7'd73: r = 8'h80; 7'd74: r = 8'hF0;
      7'd75: r = 8'hF0; 7'd76: r = 8'h80; 7'd77: r = 8'hF0; 7'd78: r = 8'h80; 7'd79: r = 8'h80;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### design/c8core_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing itself; the payload type T is chosen at each instance.
interface c8core_stream_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/c8core_datapath.sv
`timescale 1ns / 1ps
// Datapath of the CHIP-8 core: program memory, display rows, registers, stack, timers.
// Depends on c8core_pkg; driven by c8core_ctrl through dp_cmd_t.
module c8core_datapath
  import c8core_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  in_item_t    item_i,
  output dp_status_t  status_o,
  output out_item_t   result_o
);

  logic [7:0]  mem_q [MemSize];
  logic [63:0] rows_q [ScreenH];
  logic [7:0]  v_q [16];
  logic [11:0] stack_q [StackDepth];
  logic [15:0] idx_q;
  logic [11:0] pc_q;
  logic [4:0]  sp_q;
  logic [7:0]  dt_q;
  logic [7:0]  st_q;
  logic [15:0] op_q;
  logic [7:0]  rd_q;
  logic [63:0] row_q;
  logic        hit_q;
  logic [63:0] rowout_q;
  logic        drew_q;
  logic        wait_q;
  logic        fault_q;
  logic [15:0] key_q;
  logic [7:0]  rnd_q;

  logic        mem_we;
  logic [11:0] mem_wa;
  logic [7:0]  mem_wd;
  logic [11:0] mem_ra;
  logic [3:0]  x;
  logic [3:0]  y;
  logic [7:0]  nn;
  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [11:0] step_off;
  logic [5:0]  px;
  logic [4:0]  draw_r;
  logic [63:0] sprite;
  logic [127:0] sprite_w;
  logic [3:0]  hi_key;
  logic [8:0]  sum9;
  logic [7:0]  bcd_h;
  logic [7:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic [7:0]  rem100;

  assign x  = op_q[11:8];
  assign y  = op_q[7:4];
  assign nn = op_q[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign step_off = {7'd0, cmd_i.step};
  assign px = vx[5:0];
  assign draw_r = vy[4:0] + cmd_i.step;
  assign sprite_w = {rd_q, 56'd0, rd_q, 56'd0} >> px;
  assign sprite = sprite_w[127:64] | sprite_w[63:0];
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign bcd_h = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
  assign rem100 = vx - 8'(bcd_h * 8'd100);
  assign bcd_t = 8'((16'(rem100) * 16'd205) >> 11);
  assign bcd_o = rem100 - 8'(bcd_t * 8'd10);

  always_comb begin
    hi_key = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (key_q[k]) begin
        hi_key = 4'(k);
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = item_i.mem_addr;
    mem_wd = item_i.mem_byte;
    mem_ra = pc_q;
    case (cmd_i.op)
      OP_LOAD: begin
        mem_we = 1'b1;
      end
      OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = {cmd_i.step[4:0], 7'd0} + 12'(FontBase);
        mem_wd = 8'd0;
      end
      OP_FETCH_HI: mem_ra = pc_q;
      OP_FETCH_LO: mem_ra = pc_q + 12'd1;
      OP_DRAW_RD, OP_DRAW_ROW, OP_LOAD_RD: mem_ra = idx_q[11:0] + step_off;
      OP_BCD: begin
        mem_we = 1'b1;
        mem_wa = idx_q[11:0] + step_off;
        mem_wd = (cmd_i.step == 5'd0) ? bcd_h : ((cmd_i.step == 5'd1) ? bcd_t : bcd_o);
      end
      OP_STORE: begin
        mem_we = 1'b1;
        mem_wa = idx_q[11:0] + step_off;
        mem_wd = v_q[cmd_i.step[3:0]];
      end
      default: ;
    endcase
  end

  // Clearing pass after reset: one address per cycle, font glyphs or zero.
  logic [11:0] fill_q;
  logic        fill_done_q;
  logic [11:0] fill_off;
  logic        in_font;

  assign fill_off = fill_q - 12'(FontBase);
  assign in_font  = (fill_q >= 12'(FontBase)) && (fill_q < 12'(FontBase + 80));

  always_ff @(posedge clk_i) begin
    if (!fill_done_q) begin
      mem_q[fill_q] <= in_font ? font_byte(fill_off[6:0]) : 8'd0;
    end else if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      fill_done_q <= 1'b0;
    end else if (!fill_done_q) begin
      fill_q <= fill_q + 12'd1;
      fill_done_q <= (fill_q == 12'hFFF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ScreenH; i++) rows_q[i] <= '0;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
      for (int i = 0; i < StackDepth; i++) stack_q[i] <= '0;
      idx_q <= '0;
      pc_q <= PcReset;
      sp_q <= '0;
      dt_q <= '0;
      st_q <= '0;
      op_q <= '0;
      row_q <= '0;
      hit_q <= 1'b0;
      rowout_q <= '0;
      drew_q <= 1'b0;
      wait_q <= 1'b0;
      fault_q <= 1'b0;
      key_q <= '0;
      rnd_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          op_q <= '0; drew_q <= 1'b0; wait_q <= 1'b0; fault_q <= 1'b0; rowout_q <= '0;
        end
        OP_TICK: begin
          if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
          if (st_q != 8'd0) st_q <= st_q - 8'd1;
          op_q <= '0; drew_q <= 1'b0; wait_q <= 1'b0; fault_q <= 1'b0; rowout_q <= '0;
        end
        OP_ROW_RD: begin
          rowout_q <= rows_q[item_i.row_select];
          op_q <= '0; drew_q <= 1'b0; wait_q <= 1'b0; fault_q <= 1'b0;
        end
        OP_FETCH_HI: begin
          key_q <= item_i.key_mask;
          rnd_q <= item_i.random_byte;
        end
        OP_FETCH_LO: begin
          op_q[15:8] <= rd_q;
          drew_q <= 1'b0; wait_q <= 1'b0; fault_q <= 1'b0; rowout_q <= '0;
          hit_q <= 1'b0;
        end
        OP_EXEC: begin
          op_q[7:0] <= rd_q;
          pc_q <= pc_q + 12'd2;
        end
        OP_CLS: begin
          for (int i = 0; i < ScreenH; i++) rows_q[i] <= '0;
          drew_q <= 1'b1;
        end
        OP_DRAW_ROW: row_q <= rows_q[draw_r];
        OP_DRAW_WR: begin
          if ((row_q & sprite) != 64'd0) hit_q <= 1'b1;
          rows_q[draw_r] <= row_q ^ sprite;
        end
        OP_DRAW_END: begin
          v_q[15] <= {7'd0, hit_q};
          drew_q <= 1'b1;
        end
        OP_LOAD_WR: v_q[cmd_i.step[3:0]] <= rd_q;
        OP_ROW_OUT, OP_NONE, OP_DRAW_RD, OP_BCD, OP_STORE,
        OP_LOAD_RD, OP_CLEAR: ;
        default: ;
      endcase
      if (cmd_i.op == OP_ROW_OUT) begin
        case (op_q[15:12])
          4'h0: begin
            if (op_q == 16'h00EE) begin
              if (sp_q == 5'd0) fault_q <= 1'b1;
              else begin
                sp_q <= sp_q - 5'd1;
                pc_q <= stack_q[4'(sp_q - 5'd1)];
              end
            end
          end
          4'h1: pc_q <= op_q[11:0];
          4'h2: begin
            if (sp_q >= 5'(StackDepth)) fault_q <= 1'b1;
            else begin
              stack_q[4'(sp_q)] <= pc_q;
              sp_q <= sp_q + 5'd1;
              pc_q <= op_q[11:0];
            end
          end
          4'h3: if (vx == nn) pc_q <= pc_q + 12'd2;
          4'h4: if (vx != nn) pc_q <= pc_q + 12'd2;
          4'h5: if (vx == vy) pc_q <= pc_q + 12'd2;
          4'h6: v_q[x] <= nn;
          4'h7: v_q[x] <= vx + nn;
          4'h8: begin
            case (op_q[3:0])
              4'h0: v_q[x] <= vy;
              4'h1: v_q[x] <= vx | vy;
              4'h2: v_q[x] <= vx & vy;
              4'h3: v_q[x] <= vx ^ vy;
              4'h4: begin
                if (x != 4'hF) v_q[x] <= sum9[7:0];
                v_q[15] <= {7'd0, sum9[8]};
              end
              4'h5: begin
                if (x != 4'hF) v_q[x] <= vx - vy;
                v_q[15] <= {7'd0, vx >= vy};
              end
              4'h6: begin
                if (x != 4'hF) v_q[x] <= vx >> 1;
                v_q[15] <= {7'd0, vx[0]};
              end
              4'h7: begin
                if (x != 4'hF) v_q[x] <= vy - vx;
                v_q[15] <= {7'd0, vy >= vx};
              end
              4'hE: begin
                if (x != 4'hF) v_q[x] <= vx << 1;
                v_q[15] <= {7'd0, vx[7]};
              end
              default: ;
            endcase
          end
          4'h9: if (op_q[3:0] == 4'd0 && vx != vy) pc_q <= pc_q + 12'd2;
          4'hA: idx_q <= {4'd0, op_q[11:0]};
          4'hB: pc_q <= {4'd0, v_q[0]} + op_q[11:0];
          4'hC: v_q[x] <= rnd_q & nn;
          4'hE: begin
            if (nn == 8'h9E && vx < 8'd16 && key_q[vx[3:0]]) pc_q <= pc_q + 12'd2;
            else if (nn == 8'hA1 && !(vx < 8'd16 && key_q[vx[3:0]]))
              pc_q <= pc_q + 12'd2;
          end
          4'hF: begin
            case (nn)
              8'h07: v_q[x] <= dt_q;
              8'h0A: begin
                if (key_q == 16'd0) begin
                  pc_q <= pc_q - 12'd2;
                  wait_q <= 1'b1;
                end else v_q[x] <= {4'd0, hi_key};
              end
              8'h15: dt_q <= vx;
              8'h18: st_q <= vx;
              8'h1E: idx_q <= idx_q + {8'd0, vx};
              8'h29: idx_q <= 16'(FontBase) + {10'd0, vx[3:0], 2'd0} + {12'd0, vx[3:0]};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  assign status_o.opcode    = op_q;
  assign status_o.rd        = rd_q;
  assign status_o.init_done = fill_done_q;

  assign result_o.cur_pc          = pc_q;
  assign result_o.fetched_opcode  = op_q;
  assign result_o.drew            = drew_q;
  assign result_o.sound_on        = (st_q != 8'd0);
  assign result_o.row_bits        = rowout_q;
  assign result_o.waiting_for_key = wait_q;
  assign result_o.stack_fault     = fault_q;

endmodule

### design/c8core_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the CHIP-8 core: sequences fetch, execute and multi-step ops.
// Depends on c8core_pkg and the assertion macro header.
`include "chip8_instruction_core_top_assert.svh"
module c8core_ctrl
  import c8core_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_item_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_FHI   = 10'b0000000100,
    S_FLO   = 10'b0000001000,
    S_DEC   = 10'b0000010000,
    S_ALU   = 10'b0000100000,
    S_DRAW  = 10'b0001000000,
    S_MULTI = 10'b0010000000,
    S_LDV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [1:0] sub_q, sub_d;
  logic       out_q, out_d;
  logic [15:0] op;
  logic [4:0] last;

  assign op = (state_q == S_DEC) ? {status_i.opcode[15:8], status_i.rd} : status_i.opcode;
  assign in_ready_o = (state_q == S_IDLE) && !out_q;
  assign out_valid_o = out_q;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    sub_d = sub_q;
    out_d = out_q && !out_ready_i;
    cmd_o.op = OP_NONE;
    cmd_o.step = step_q;
    last = {1'b0, op[11:8]};
    case (state_q)
      S_INIT: begin
        state_d = status_i.init_done ? S_IDLE : S_INIT;
        cmd_o.op = OP_NONE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          case (func_e'(in_item_i.func))
            FUNC_LOAD: begin cmd_o.op = OP_LOAD; out_d = 1'b1; end
            FUNC_TICK: begin cmd_o.op = OP_TICK; out_d = 1'b1; end
            FUNC_ROW:  begin cmd_o.op = OP_ROW_RD; out_d = 1'b1; end
            FUNC_EXEC: begin cmd_o.op = OP_FETCH_HI; state_d = S_FLO; end
            default: ;
          endcase
        end
      end
      S_FLO: begin
        cmd_o.op = OP_FETCH_LO;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.op = OP_EXEC;
        step_d = 5'd0;
        sub_d = 2'd0;
        if (op == 16'h00E0) state_d = S_ALU;
        else if (op[15:12] == 4'hD) state_d = (op[3:0] == 4'd0) ? S_ALU : S_DRAW;
        else if (op[15:12] == 4'hF && (op[7:0] == 8'h33 || op[7:0] == 8'h55))
          state_d = S_MULTI;
        else if (op[15:12] == 4'hF && op[7:0] == 8'h65) state_d = S_LDV;
        else state_d = S_ALU;
      end
      S_ALU: begin
        if (op == 16'h00E0) cmd_o.op = OP_CLS;
        else if (op[15:12] == 4'hD) cmd_o.op = OP_DRAW_END;
        else if (op[15:12] == 4'hF && (op[7:0] == 8'h33 || op[7:0] == 8'h55 ||
                 op[7:0] == 8'h65)) cmd_o.op = OP_NONE;
        else cmd_o.op = OP_ROW_OUT;
        state_d = S_OUT;
      end
      S_DRAW: begin
        case (sub_q)
          2'd0: begin cmd_o.op = OP_DRAW_RD; sub_d = 2'd1; end
          2'd1: begin cmd_o.op = OP_DRAW_ROW; sub_d = 2'd2; end
          default: begin
            cmd_o.op = OP_DRAW_WR;
            sub_d = 2'd0;
            step_d = step_q + 5'd1;
            if (step_q == {1'b0, op[3:0]} - 5'd1) state_d = S_ALU;
          end
        endcase
      end
      S_MULTI: begin
        if (op[7:0] == 8'h33) begin
          cmd_o.op = OP_BCD;
          last = 5'd2;
        end else cmd_o.op = OP_STORE;
        step_d = step_q + 5'd1;
        if (step_q == last) state_d = S_ALU;
      end
      S_LDV: begin
        if (sub_q == 2'd0) begin
          cmd_o.op = OP_LOAD_RD;
          sub_d = 2'd1;
        end else begin
          cmd_o.op = OP_LOAD_WR;
          sub_d = 2'd0;
          step_d = step_q + 5'd1;
          if (step_q == last) state_d = S_ALU;
        end
      end
      S_OUT: begin
        out_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      step_q <= '0;
      sub_q <= '0;
      out_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      sub_q <= sub_d;
      out_q <= out_d;
    end
  end

  `C8_ASSERT_IMP(a_one_hot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `C8_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `C8_ASSERT_NEXT(a_out_after, clk_i, rst_ni, state_q == S_OUT, out_valid_o)

endmodule

### design/chip8_instruction_core_top.sv
`timescale 1ns / 1ps
// Top level of the CHIP-8 instruction core: controller plus datapath on two channels.
// Depends on c8core_pkg, c8core_stream_if, c8core_ctrl, c8core_datapath.
// One item at a time. A load, tick or row read is done on acceptance; an instruction
// is fetched in two halves, then executed, with steps for each sprite row of DXYN,
// each BCD digit of FX33 and each register of FX55 and FX65. The result register
// hands over one transaction per item; a new item is taken once it is gone. After
// reset a clearing pass over all 4096 addresses writes the font and zeroes the rest
// of program memory; no item is taken before it ends.
`include "chip8_instruction_core_top_assert.svh"
module chip8_instruction_core_top
  import c8core_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  c8core_stream_if.sink     in_i,
  c8core_stream_if.source   out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  out_item_t  result;

  c8core_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  c8core_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_i.data),
    .status_o (status),
    .result_o (result)
  );

  assign out_o.data = result;

  `C8_ASSERT_IMP(a_exclusive, clk_i, rst_ni, out_o.valid, !in_i.ready)
  `C8_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid)

endmodule
